[hdl/chunk_hash_directory_top_defines.svh]
// ----------------------------------------------------------------------------
// Chunk hash directory assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef CHUNK_HASH_DIRECTORY_TOP_DEFINES_SVH
`define CHUNK_HASH_DIRECTORY_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/chd_pkg.sv]
// ----------------------------------------------------------------------------
// Chunk hash directory package
// Default sizes, hash primes and result status codes.
// ----------------------------------------------------------------------------
package chd_pkg;

  // Default table and key sizes
  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int COORD_BITS_DEF  = 16;

  // Hash multipliers, one per coordinate
  localparam logic [31:0] PRIME_X = 32'd73856093;
  localparam logic [31:0] PRIME_Y = 32'd19349663;
  localparam logic [31:0] PRIME_Z = 32'd83492791;

  // Result status codes
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_MISS     = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

[hdl/chunk_hash_directory_top.sv]
// Flow: one request at a time; an accepted request has its hash products registered,
//   its home slot read, then a probe walk of k slots, one slot per cycle, from the valid
//   and key memories (1 <= k <= TABLE_SLOTS), before the result is registered.
// Reset: rst is synchronous; afterwards a clearing pass writes every valid entry
//   to zero, with in_tready low until it finishes.
// ----------------------------------------------------------------------------
// Chunk hash directory
// Open-addressing table of 3-D chunk keys with linear probing and insert.
// ----------------------------------------------------------------------------
module chunk_hash_directory_top
  import chd_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int IDX_W      = $clog2(TABLE_SLOTS),
  localparam int KEY_W      = 3 * COORD_BITS,
  localparam int IN_W       = ((KEY_W + 7) / 8) * 8,
  localparam int OUT_W      = ((2 * IDX_W + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // key_x, key_y, key_z, zero pad
  input  logic             in_tuser,   // mode
  // result channel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // slot, occupied, zero pad
  output logic [1:0]       out_tuser   // status
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_HASH,
    S_PROBE
  } state_t;

  state_t state;

  // request registers
  logic                         mode;
  logic signed [COORD_BITS-1:0] key_x;
  logic signed [COORD_BITS-1:0] key_y;
  logic signed [COORD_BITS-1:0] key_z;
  logic [31:0]                  prod_x;
  logic [31:0]                  prod_y;
  logic [31:0]                  prod_z;

  // probe and bookkeeping
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W:0]   probes;
  logic [IDX_W:0]   fill;

  // memories
  logic             valid_mem [TABLE_SLOTS];
  logic [KEY_W-1:0] key_mem   [TABLE_SLOTS];
  logic             valid_q;
  logic [KEY_W-1:0] key_q;

  // memory controls
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             v_we;
  logic [IDX_W-1:0] v_waddr;
  logic             v_wdata;
  logic             k_we;

  logic [IDX_W-1:0] hash_idx;
  logic [KEY_W-1:0] key_cat;
  logic             hit;
  logic             empty;
  logic             last;
  logic             done;
  logic             out_free;
  logic             claim;
  logic             res_load;

  assign in_tready = (state == S_IDLE);
  assign out_free  = !out_tvalid || out_tready;

  // home slot: low index bits of the xor of the wrapped products
  assign hash_idx = IDX_W'(prod_x ^ prod_y ^ prod_z);
  assign key_cat  = {key_z, key_y, key_x};

  // probe outcome for the slot whose data is on the read registers
  assign hit      = valid_q && (key_q == key_cat);
  assign empty    = !valid_q;
  assign last     = (probes == (IDX_W + 1)'(TABLE_SLOTS));
  assign done     = empty || hit || last;
  assign claim    = (state == S_PROBE) && empty && mode && out_free;
  assign res_load = (state == S_PROBE) && done && out_free;

  // read port: home slot first, then one step forward per cycle
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = hash_idx;
    case (state)
      S_HASH: begin
        rd_en   = 1'b1;
        rd_addr = hash_idx;
      end
      S_PROBE: begin
        rd_en   = !done;
        rd_addr = IDX_W'(cur_idx + 1'b1);
      end
      default: begin
        rd_en   = 1'b0;
      end
    endcase
  end

  // write port: clearing pass, or claim of an empty slot
  always_comb begin
    v_we    = 1'b0;
    v_waddr = cur_idx;
    v_wdata = 1'b1;
    k_we    = 1'b0;
    if (state == S_CLEAR) begin
      v_we    = 1'b1;
      v_waddr = clr_idx;
      v_wdata = 1'b0;
    end else if (claim) begin
      v_we    = 1'b1;
      k_we    = 1'b1;
    end
  end

  // valid memory
  always_ff @(posedge clk) begin
    if (v_we) begin
      valid_mem[v_waddr] <= v_wdata;
    end
    if (rd_en) begin
      valid_q <= valid_mem[rd_addr];
    end
  end

  // key memory
  always_ff @(posedge clk) begin
    if (k_we) begin
      key_mem[cur_idx] <= key_cat;
    end
    if (rd_en) begin
      key_q <= key_mem[rd_addr];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      fill       <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (out_tvalid && out_tready && !res_load) begin
        out_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= IDX_W'(clr_idx + 1'b1);
          if (clr_idx == IDX_W'(TABLE_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            mode  <= in_tuser;
            key_x <= in_tdata[COORD_BITS-1:0];
            key_y <= in_tdata[2*COORD_BITS-1:COORD_BITS];
            key_z <= in_tdata[3*COORD_BITS-1:2*COORD_BITS];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_x <= 32'(32'(key_x) * PRIME_X);
          prod_y <= 32'(32'(key_y) * PRIME_Y);
          prod_z <= 32'(32'(key_z) * PRIME_Z);
          state  <= S_HASH;
        end
        S_HASH: begin
          cur_idx <= hash_idx;
          probes  <= (IDX_W + 1)'(1);
          state   <= S_PROBE;
        end
        S_PROBE: begin
          if (!done) begin
            cur_idx <= IDX_W'(cur_idx + 1'b1);
            probes  <= (IDX_W + 1)'(probes + 1'b1);
          end else if (out_free) begin
            // result; a busy output holds the probe data until it drains
            out_tvalid <= 1'b1;
            state      <= S_IDLE;
            if (hit) begin
              out_tuser <= ST_FOUND;
              out_tdata <= OUT_W'({fill, cur_idx});
            end else if (empty && mode) begin
              fill      <= (IDX_W + 1)'(fill + 1'b1);
              out_tuser <= ST_INSERTED;
              out_tdata <= OUT_W'({(IDX_W + 1)'(fill + 1'b1), cur_idx});
            end else if (empty || !mode) begin
              out_tuser <= ST_MISS;
              out_tdata <= OUT_W'({fill, IDX_W'(0)});
            end else begin
              out_tuser <= ST_FULL;
              out_tdata <= OUT_W'({fill, IDX_W'(0)});
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/chd_checker.sv]
// ----------------------------------------------------------------------------
// Chunk hash directory checker
// Port-level assertions on the directory, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "chunk_hash_directory_top_defines.svh"

module chd_checker
  import chd_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int IDX_W      = $clog2(TABLE_SLOTS),
  localparam int OUT_W      = ((2 * IDX_W + 1 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,  // slot, occupied, zero pad
  input logic [1:0]       out_tuser   // status
);

  logic [IDX_W-1:0] slot;
  logic [IDX_W:0]   occ;
  logic             no_slot;

  assign slot    = out_tdata[IDX_W-1:0];
  assign occ     = out_tdata[2*IDX_W:IDX_W];
  assign no_slot = (out_tuser == ST_MISS) || (out_tuser == ST_FULL);

  // a stalled result holds
  `CHD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // misses and full reports carry slot zero
  `CHD_ASSERT_SAME(a_miss_slot, out_tvalid && no_slot, slot == '0, "nonzero slot on miss or full")

  // occupancy stays within the table
  `CHD_ASSERT_SAME(a_occ_range, out_tvalid, occ <= (IDX_W + 1)'(TABLE_SLOTS), "occupancy beyond table size")

  // an insert leaves at least one slot in use
  `CHD_ASSERT_SAME(a_ins_occ, out_tvalid && (out_tuser == ST_INSERTED), occ != '0, "insert with zero occupancy")

  // no request taken right after reset, while the table clears
  `CHD_ASSERT_SAME(a_clear_block, $past(rst), !in_tready, "request taken during clearing pass")

endmodule

bind chunk_hash_directory_top chd_checker #(
  .TABLE_SLOTS (TABLE_SLOTS),
  .COORD_BITS  (COORD_BITS)
) u_chd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Chunk hash directory testbench
// Streams lookup and insert requests into the linear-probing directory and
// checks every result against a local model of the table. A short directed
// table covers the empty table, probe collisions, wrap-around and the key
// extremes. Random traffic then fills the table to capacity and keeps hitting
// it once full. Both stream sides idle at random, and the result side holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench
  import chd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = TABLE_SLOTS_DEF;
  localparam int COORD_BITS  = COORD_BITS_DEF;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);
  localparam int KEY_W       = 3 * COORD_BITS;
  localparam int IN_W        = ((KEY_W + 7) / 8) * 8;
  localparam int OUT_W       = ((2 * IDX_W + 1 + 7) / 8) * 8;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  localparam int DIRECTED_COUNT = 21;
  localparam int FILL_TARGET    = 1100;  // fresh inserts, well past capacity
  localparam int FULL_ITEMS     = 100;   // requests against the full table
  localparam int HOLD_AFTER     = 400;   // requests before the long result stall
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 6000;  // full walk + clearing pass + hold, with margin

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot;
    logic [IDX_W:0]   occupied;
  } dir_result_t;

  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] key_x;
    logic [COORD_BITS-1:0] key_y;
    logic [COORD_BITS-1:0] key_z;
    logic                  has_ref;
    logic [1:0]            status;
    logic [IDX_W-1:0]      slot;
    logic [IDX_W:0]        occupied;
  } dir_row_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE} ready_style_t;

  // DUT ports
  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // key_x, key_y, key_z, zero pad
  logic             in_tuser   = 1'b0; // mode
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // slot, occupied, zero pad
  logic [1:0]       out_tuser;         // status

  // Hand-checked expectation riding along with the current request
  logic        row_has_ref = 1'b0;
  dir_result_t row_ref     = '0;

  // Local copy of the directory
  logic                 dir_valid [TABLE_SLOTS];
  logic [KEY_W-1:0]     dir_key   [TABLE_SLOTS];
  logic [IDX_W:0]       dir_fill = '0;

  dir_result_t          pending_results [$];
  logic [KEY_W-1:0]     known_keys [$];

  int           requests_seen = 0;
  int           results_seen  = 0;
  int           mismatches    = 0;
  int           status_tally [4] = '{0, 0, 0, 0};
  int           idle_cycles   = 0;
  int           burst_left    = 0;
  logic         result_hold   = 1'b0;
  ready_style_t ready_style   = READY_ALWAYS;
  int           style_left    = 0;

  // Directed table: empty table, collisions on slot 0, wrap from slot 1023,
  // coordinate extremes. Rows with has_ref set carry a hand-worked result.
  dir_row_t directed_rows [DIRECTED_COUNT] = '{
    '{MODE_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b1, ST_MISS,     10'd0,    11'd0},
    '{MODE_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b1, ST_INSERTED, 10'd0,    11'd1},
    '{MODE_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b1, ST_FOUND,    10'd0,    11'd1},
    '{MODE_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b1, ST_FOUND,    10'd0,    11'd1},
    '{MODE_INSERT, 16'h0001, 16'h0000, 16'h0000, 1'b1, ST_INSERTED, 10'd93,   11'd2},
    '{MODE_INSERT, 16'h0000, 16'h0001, 16'h0000, 1'b1, ST_INSERTED, 10'd159,  11'd3},
    '{MODE_INSERT, 16'h0000, 16'h0000, 16'h0001, 1'b1, ST_INSERTED, 10'd951,  11'd4},
    '{MODE_INSERT, 16'h0400, 16'h0000, 16'h0000, 1'b1, ST_INSERTED, 10'd1,    11'd5},
    '{MODE_LOOKUP, 16'h0800, 16'h0000, 16'h0000, 1'b1, ST_MISS,     10'd0,    11'd5},
    '{MODE_INSERT, 16'h0000, 16'h0000, 16'h8000, 1'b1, ST_INSERTED, 10'd2,    11'd6},
    '{MODE_INSERT, 16'h8000, 16'h8000, 16'h8000, 1'b1, ST_INSERTED, 10'd3,    11'd7},
    '{MODE_INSERT, 16'h000B, 16'h0000, 16'h0000, 1'b1, ST_INSERTED, 10'd1023, 11'd8},
    '{MODE_INSERT, 16'h040B, 16'h0000, 16'h0000, 1'b1, ST_INSERTED, 10'd4,    11'd9},
    '{MODE_LOOKUP, 16'h040B, 16'h0000, 16'h0000, 1'b1, ST_FOUND,    10'd4,    11'd9},
    '{MODE_LOOKUP, 16'h8000, 16'h8000, 16'h8000, 1'b1, ST_FOUND,    10'd3,    11'd9},
    '{MODE_INSERT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, ST_FOUND,    10'd0,    11'd0},
    '{MODE_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, ST_FOUND,    10'd0,    11'd0},
    '{MODE_INSERT, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, ST_FOUND,    10'd0,    11'd0},
    '{MODE_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, ST_FOUND,    10'd0,    11'd0},
    '{MODE_LOOKUP, 16'h8000, 16'h7FFF, 16'h0001, 1'b0, ST_FOUND,    10'd0,    11'd0},
    '{MODE_INSERT, 16'h5555, 16'hAAAA, 16'h0000, 1'b0, ST_FOUND,    10'd0,    11'd0}
  };

  chunk_hash_directory_top #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .COORD_BITS  (COORD_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Probe the local directory for one request and update it as the block would
  function automatic dir_result_t probe_directory(input logic mode,
                                                  input logic [KEY_W-1:0] key);
    logic [31:0]      hash;
    logic [IDX_W-1:0] idx;
    dir_result_t      res;
    // products wrap at 32 bits on the sign-extended coordinates
    hash = ({{(32-COORD_BITS){key[COORD_BITS-1]}}, key[COORD_BITS-1:0]} * PRIME_X)
         ^ ({{(32-COORD_BITS){key[2*COORD_BITS-1]}}, key[2*COORD_BITS-1:COORD_BITS]}
            * PRIME_Y)
         ^ ({{(32-COORD_BITS){key[3*COORD_BITS-1]}}, key[3*COORD_BITS-1:2*COORD_BITS]}
            * PRIME_Z);
    res.status = mode ? ST_FULL : ST_MISS;
    res.slot   = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      idx = hash[IDX_W-1:0] + IDX_W'(i);
      if (!dir_valid[idx]) begin
        if (mode) begin
          dir_valid[idx] = 1'b1;
          dir_key[idx]   = key;
          dir_fill       = dir_fill + 1'b1;
          res.status     = ST_INSERTED;
          res.slot       = idx;
        end else begin
          res.status = ST_MISS;
        end
        break;
      end
      if (dir_key[idx] == key) begin
        res.status = ST_FOUND;
        res.slot   = idx;
        break;
      end
    end
    res.occupied = dir_fill;
    return res;
  endfunction

  // Wide random keys, with some drawn from a tight cluster around the origin
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] key;
    if ($urandom_range(0, 99) < 15) begin
      for (int c = 0; c < 3; c++)
        key[COORD_BITS*c +: COORD_BITS] = COORD_BITS'($urandom_range(0, 15)) - 16'd8;
    end else begin
      key = {16'($urandom), 16'($urandom), 16'($urandom)};
    end
    return key;
  endfunction

  function automatic logic [KEY_W-1:0] pick_known_key();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // Offer one request, wait for it to be taken, then pace the next one
  task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                              input logic has_ref, input dir_result_t ref_result);
    in_tvalid   <= 1'b1;
    in_tuser    <= mode;
    in_tdata    <= IN_W'(key);
    row_has_ref <= has_ref;
    row_ref     <= ref_result;
    do @(posedge clk); while (!in_tready);
    // bursts of random length, mostly separated by random gaps
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic flag_mismatch(input string field, input int want, input int got);
    mismatches++;
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  // Stimulus
  initial begin
    dir_row_t         row;
    logic [KEY_W-1:0] key;
    int               pick;
    int               fresh_inserts;
    for (int i = 0; i < TABLE_SLOTS; i++)
      dir_valid[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      row = directed_rows[r];
      key = {row.key_z, row.key_y, row.key_x};
      if (row.mode == MODE_INSERT)
        known_keys.push_back(key);
      send_request(row.mode, key, row.has_ref, '{row.status, row.slot, row.occupied});
    end

    // Fill phase: mostly fresh inserts, with hits, repeats and misses mixed in
    fresh_inserts = 0;
    while (fresh_inserts < FILL_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        key = random_key();
        known_keys.push_back(key);
        fresh_inserts++;
        send_request(MODE_INSERT, key, 1'b0, '0);
      end else if (pick < 93) begin
        send_request(MODE_LOOKUP, pick_known_key(), 1'b0, '0);
      end else if (pick < 96) begin
        send_request(MODE_INSERT, pick_known_key(), 1'b0, '0);
      end else begin
        send_request(MODE_LOOKUP, random_key(), 1'b0, '0);
      end
    end

    // Full table: present keys hit, absent keys walk the whole table
    repeat (FULL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)
        send_request(MODE_LOOKUP, pick_known_key(), 1'b0, '0);
      else if (pick < 45)
        send_request(MODE_INSERT, pick_known_key(), 1'b0, '0);
      else if (pick < 75)
        send_request(MODE_INSERT, random_key(), 1'b0, '0);
      else
        send_request(MODE_LOOKUP, random_key(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d found, %0d inserted, %0d lookup misses, %0d rejected full",
             requests_seen, status_tally[ST_FOUND], status_tally[ST_INSERTED],
             status_tally[ST_MISS], status_tally[ST_FULL]);
    $display("Directory occupancy reached %0d of %0d slots, %0d results checked",
             dir_fill, TABLE_SLOTS, results_seen);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side readiness: changing styles, including stretches always ready
  always @(posedge clk) begin
    logic ready_now;
    if (style_left == 0) begin
      ready_style <= ready_style_t'($urandom_range(0, 2));
      style_left  <= $urandom_range(32, 256);
    end else begin
      style_left <= style_left - 1;
    end
    case (ready_style)
      READY_ALWAYS: ready_now = 1'b1;
      READY_HALF:   ready_now = $urandom_range(0, 1) == 1;
      default:      ready_now = $urandom_range(0, 3) == 0;
    endcase
    out_tready <= ready_now && !result_hold;
  end

  // Long result stall while requests keep coming, so the input backs up
  initial begin
    do @(posedge clk); while (requests_seen < HOLD_AFTER);
    result_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    result_hold <= 1'b0;
  end

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    dir_result_t got;
    dir_result_t want;
    if (!rst) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.status   = out_tuser;
        got.slot     = out_tdata[IDX_W-1:0];
        got.occupied = out_tdata[2*IDX_W:IDX_W];
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, got status %0d slot %0d",
                   $time, got.status, got.slot);
        end else begin
          want = pending_results.pop_front();
          status_tally[want.status]++;
          if (got.status !== want.status)
            flag_mismatch("status", want.status, got.status);
          if (got.slot !== want.slot)
            flag_mismatch("slot", want.slot, got.slot);
          if (got.occupied !== want.occupied)
            flag_mismatch("occupied", want.occupied, got.occupied);
        end
      end
      if (in_tvalid && in_tready) begin
        requests_seen++;
        want = probe_directory(in_tuser, in_tdata[KEY_W-1:0]);
        if (row_has_ref)
          want = row_ref;
        pending_results.push_back(want);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
